[hdl/dcdr_pkg.sv]
package dcdr_pkg;

  // repeat period of the frame timer, in output ticks
  localparam int REPEAT_TICKS = 20;
  localparam int TIMER_W = 5;
  localparam logic [TIMER_W-1:0] TIMER_RELOAD = TIMER_W'(REPEAT_TICKS);
  localparam logic [TIMER_W-1:0] TIMER_RELOAD_M1 = TIMER_W'(REPEAT_TICKS - 1);

  localparam logic [7:0] LEVEL_MAX = 8'd254;

  // configuration register reset values
  localparam logic [7:0] STEPS_RESET = 8'd3;
  localparam logic [7:0] MIN_LEVEL_RESET = 8'd144;

  // configuration register indexes
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_PARALLEL = 2'd0;
  localparam logic [1:0] REG_STEPS = 2'd1;
  localparam logic [1:0] REG_MIN_LEVEL = 2'd2;
  localparam logic [1:0] REG_EXT_MODE = 2'd3;

  // tick kinds
  localparam logic OP_RAMP = 1'b0;
  localparam logic OP_OUTPUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RAMP,
    ST_OUTPUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       operation;
    logic       ch1_status_on;
    logic       ch2_status_on;
    logic       ch1_lux_hold;
    logic       ch1_lamp_on;
    logic       ch2_lamp_on;
    logic [7:0] ch1_target;
    logic [7:0] ch2_target;
    logic [7:0] ext_level_ch1;
    logic [7:0] ext_level_ch2;
    logic [7:0] ch1_force_load;
    logic [7:0] ch2_force_load;
  } item_t;

  typedef struct packed {
    logic       send_frame;
    logic [7:0] frame_ch1;
    logic [7:0] frame_ch2;
    logic [7:0] level_ch1;
    logic [7:0] level_ch2;
  } result_t;

  // clamp to the top level and force by lamp state
  function automatic logic [7:0] force_level(input logic [7:0] lvl, input logic lamp_on);
    logic [7:0] c;
    c = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
    if (!lamp_on) begin
      return 8'd0;
    end
    if (c == 8'd0) begin
      return 8'd1;
    end
    return c;
  endfunction

endpackage

[hdl/dcdr_ramp_step.sv]
module dcdr_ramp_step (
  input  logic [7:0] lvl,
  input  logic       on,
  input  logic [7:0] target,
  input  logic [7:0] min_level,
  output logic [7:0] lvl_next
);
  import dcdr_pkg::*;

  // one step toward the target (a level below the floor jumps to it), or when off, down to the floor and then off
  always_comb begin
    priority if (!on) begin
      lvl_next = (lvl > min_level) ? lvl - 8'd1 : 8'd0;
    end else if (lvl < min_level) begin
      lvl_next = min_level;
    end else if (lvl < target) begin
      lvl_next = lvl + 8'd1;
    end else if (lvl > target) begin
      lvl_next = lvl - 8'd1;
    end else begin
      lvl_next = lvl;
    end
  end

endmodule

[hdl/dual_channel_dim_ramp_and_send.sv]
// ramp tick: the shared step unit visits channel 1 then channel 2 once per single
// step, for steps_per_tick steps in ST_RAMP, then ST_DONE loads the result register
// output tick: ST_OUTPUT, then ST_DONE loads the result register
// a new tick is taken only in ST_IDLE, once the last result is loaded; ST_DONE
// waits while a finished result waits on a stalled result register
// rst (synchronous, active high): block state but the captured item to 0, registers to defaults, no result
module dual_channel_dim_ramp_and_send (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dcdr_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output dcdr_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dcdr_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dcdr_pkg::*;

  // configuration registers
  logic       parallel_mode;
  logic [7:0] steps_per_tick;
  logic [7:0] min_level;
  logic [1:0] external_source_mode;

  // block state
  state_t             state, state_next;
  item_t              item_reg;
  logic [7:0]         step_count;
  logic               chan;
  logic               send_reg;
  logic [7:0]         ramp_level_one, ramp_level_two;
  logic [7:0]         last_sent_one, last_sent_two;
  logic [TIMER_W-1:0] repeat_timer;
  logic [7:0]         force_count_one, force_count_two;

  // control from the sequencer
  logic take_item;
  logic load_result;

  // shared step unit
  logic [7:0] su_lvl, su_target, su_next;
  logic       su_on;

  // output tick values
  logic [7:0]         out_lvl1, out_lvl2, ls1, ls2, f1, f2;
  logic [7:0]         fc1_next, fc2_next;
  logic [7:0]         sent1_next, sent2_next;
  logic [TIMER_W-1:0] timer_next;
  logic               send_next;
  logic               changed;

  // register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parallel_mode <= 1'b0;
      steps_per_tick <= STEPS_RESET;
      min_level <= MIN_LEVEL_RESET;
      external_source_mode <= 2'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PARALLEL:  parallel_mode <= pwdata[0];
        REG_STEPS:     steps_per_tick <= pwdata[7:0];
        REG_MIN_LEVEL: min_level <= pwdata[7:0];
        REG_EXT_MODE:  external_source_mode <= pwdata[1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PARALLEL:  prdata = {31'd0, parallel_mode};
      REG_STEPS:     prdata = {24'd0, steps_per_tick};
      REG_MIN_LEVEL: prdata = {24'd0, min_level};
      REG_EXT_MODE:  prdata = {30'd0, external_source_mode};
      default:       prdata = 32'd0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.operation == OP_OUTPUT) begin
            state_next = ST_OUTPUT;
          end else if (steps_per_tick == 8'd0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RAMP;
          end
        end
      end
      ST_RAMP: begin
        if (chan && step_count == 8'd1) begin
          state_next = ST_DONE;
        end
      end
      ST_OUTPUT: state_next = ST_DONE;
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_stall = 1'b1;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE:   item_stall = 1'b0;
      ST_RAMP:   ;
      ST_OUTPUT: ;
      ST_DONE:   load_result = !result_valid || !result_stall;
      default:   ;
    endcase
  end

  assign take_item = item_valid && !item_stall;

  // shared step unit, one channel per cycle
  assign su_lvl    = chan ? ramp_level_two : ramp_level_one;
  assign su_on     = chan ? item_reg.ch2_status_on : item_reg.ch1_status_on;
  assign su_target = chan ? item_reg.ch2_target : item_reg.ch1_target;

  dcdr_ramp_step u_step (
    .lvl       (su_lvl),
    .on        (su_on),
    .target    (su_target),
    .min_level (min_level),
    .lvl_next  (su_next)
  );

  // output tick: forcing, force counters, change check and repeat timer
  always_comb begin
    out_lvl1 = force_level(ramp_level_one, item_reg.ch1_lamp_on);
    ls1 = (force_count_one != 8'd0) ? 8'd0 : last_sent_one;
    fc1_next = (force_count_one != 8'd0) ? force_count_one - 8'd1 : force_count_one;
    if (parallel_mode) begin
      out_lvl2 = out_lvl1;
      ls2 = last_sent_two;
      fc2_next = force_count_two;
    end else begin
      out_lvl2 = force_level(ramp_level_two, item_reg.ch2_lamp_on);
      ls2 = (force_count_two != 8'd0) ? 8'd0 : last_sent_two;
      fc2_next = (force_count_two != 8'd0) ? force_count_two - 8'd1 : force_count_two;
    end
    f1 = external_source_mode[0] ? item_reg.ext_level_ch1 : out_lvl1;
    f2 = external_source_mode[1] ? item_reg.ext_level_ch2 : out_lvl2;
    changed = (f1 != ls1) || (f2 != ls2);
    sent1_next = changed ? f1 : ls1;
    sent2_next = changed ? f2 : ls2;
    priority if (changed) begin
      send_next = 1'b1;
      timer_next = TIMER_RELOAD - TIMER_W'(1);
    end else if (repeat_timer != '0) begin
      send_next = 1'b0;
      timer_next = repeat_timer - TIMER_W'(1);
    end else begin
      send_next = 1'b1;
      timer_next = TIMER_RELOAD_M1;
    end
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ramp_level_one <= 8'd0;
      ramp_level_two <= 8'd0;
      last_sent_one <= 8'd0;
      last_sent_two <= 8'd0;
      repeat_timer <= '0;
      force_count_one <= 8'd0;
      force_count_two <= 8'd0;
      send_reg <= 1'b0;
      chan <= 1'b0;
      step_count <= 8'd0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (take_item) begin
            if (item.ch1_force_load != 8'd0) begin
              force_count_one <= item.ch1_force_load;
            end
            if (item.ch2_force_load != 8'd0) begin
              force_count_two <= item.ch2_force_load;
            end
            step_count <= steps_per_tick;
            chan <= 1'b0;
            send_reg <= 1'b0;
          end
        end
        ST_RAMP: begin
          if (!chan) begin
            if (!item_reg.ch1_lux_hold) begin
              ramp_level_one <= su_next;
            end
          end else begin
            if (!parallel_mode) begin
              ramp_level_two <= su_next;
            end
            step_count <= step_count - 8'd1;
          end
          chan <= !chan;
        end
        ST_OUTPUT: begin
          ramp_level_one <= out_lvl1;
          ramp_level_two <= out_lvl2;
          force_count_one <= fc1_next;
          force_count_two <= fc2_next;
          last_sent_one <= sent1_next;
          last_sent_two <= sent2_next;
          repeat_timer <= timer_next;
          send_reg <= send_next;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (take_item) begin
      item_reg <= item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.send_frame <= send_reg;
      result.frame_ch1 <= last_sent_one;
      result.frame_ch2 <= last_sent_two;
      result.level_ch1 <= ramp_level_one;
      result.level_ch2 <= ramp_level_two;
    end
  end

  // checks
  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> state == ST_IDLE)
    else $error("item taken outside idle");

  a_ramp_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_RAMP |-> step_count != 8'd0)
    else $error("ramp sequencer running with no steps left");

  a_ramp_no_send: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && item_reg.operation == OP_RAMP) |-> !send_reg)
    else $error("ramp tick flagged a frame");

  a_timer_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> repeat_timer < TIMER_RELOAD)
    else $error("repeat timer out of range");

  a_output_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && item_reg.operation == OP_OUTPUT) |->
      (ramp_level_one != 8'd255 && ramp_level_two != 8'd255))
    else $error("level not clamped after output tick");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import dcdr_pkg::*;

  localparam int TICKS_PER_SETTING = 75;
  localparam int NUM_SETTINGS = 12;
  localparam int DRAIN_CYCLES = 600;

  // one directed row: the tick and, where it is plain, the result typed in
  typedef struct {
    item_t   tick;
    bit      fixed;
    result_t want;
  } dir_row_t;

  typedef struct {
    bit      fixed;
    result_t want;
  } tick_note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register copies used by the predictor
  logic       cfg_parallel = 1'b0;
  logic [7:0] cfg_steps = STEPS_RESET;
  logic [7:0] cfg_min = MIN_LEVEL_RESET;
  logic [1:0] cfg_ext = 2'd0;

  // predicted controller state
  logic [7:0] lvl_one = '0;
  logic [7:0] lvl_two = '0;
  logic [7:0] sent_one = '0;
  logic [7:0] sent_two = '0;
  logic [TIMER_W-1:0] repeat_left = '0;
  logic [7:0] resend_one = '0;
  logic [7:0] resend_two = '0;

  result_t    pending_frames[$];
  tick_note_t tick_notes[$];

  int errors = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int frames_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  item_t scene = '0;

  dual_channel_dim_ramp_and_send u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one step of a channel toward its target (a level below the floor jumps to it), or down and off
  function automatic logic [7:0] step_toward(input logic [7:0] lvl, input logic on,
                                             input logic [7:0] tgt);
    if (!on) begin
      return (lvl > cfg_min) ? lvl - 8'd1 : 8'd0;
    end
    if (lvl < cfg_min) return cfg_min;
    if (lvl < tgt) return lvl + 8'd1;
    if (lvl > tgt) return lvl - 8'd1;
    return lvl;
  endfunction

  // output clamp, then at least 1 when lit and 0 when dark
  function automatic logic [7:0] clamp_to_lamp(input logic [7:0] lvl, input logic lit);
    if (!lit) return 8'd0;
    if (lvl == 8'd0) return 8'd1;
    return (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
  endfunction

  // advance the dimmer state by one tick and return the frame it reports
  function automatic result_t dim_tick(input item_t t);
    result_t r;
    logic [7:0] pick_one, pick_two;
    logic send;
    int n;
    send = 1'b0;
    if (t.ch1_force_load != 8'd0) resend_one = t.ch1_force_load;
    if (t.ch2_force_load != 8'd0) resend_two = t.ch2_force_load;
    if (t.operation == OP_RAMP) begin
      for (n = 0; n < cfg_steps; n++) begin
        if (!t.ch1_lux_hold) lvl_one = step_toward(lvl_one, t.ch1_status_on, t.ch1_target);
        if (!cfg_parallel) lvl_two = step_toward(lvl_two, t.ch2_status_on, t.ch2_target);
      end
    end else begin
      lvl_one = clamp_to_lamp(lvl_one, t.ch1_lamp_on);
      if (resend_one != 8'd0) begin
        resend_one = resend_one - 8'd1;
        sent_one = 8'd0;
      end
      if (!cfg_parallel) begin
        lvl_two = clamp_to_lamp(lvl_two, t.ch2_lamp_on);
        if (resend_two != 8'd0) begin
          resend_two = resend_two - 8'd1;
          sent_two = 8'd0;
        end
      end else begin
        lvl_two = lvl_one;
      end
      pick_one = cfg_ext[0] ? t.ext_level_ch1 : lvl_one;
      pick_two = cfg_ext[1] ? t.ext_level_ch2 : lvl_two;
      if (pick_one != sent_one || pick_two != sent_two) begin
        sent_one = pick_one;
        sent_two = pick_two;
        send = 1'b1;
        repeat_left = TIMER_RELOAD;
      end
      if (repeat_left != '0) begin
        repeat_left = repeat_left - 1'b1;
      end else begin
        send = 1'b1;
        repeat_left = TIMER_RELOAD_M1;
      end
    end
    r.send_frame = send;
    r.frame_ch1 = sent_one;
    r.frame_ch2 = sent_two;
    r.level_ch1 = lvl_one;
    r.level_ch2 = lvl_two;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // transfer monitor: predict on accepted ticks, compare accepted results
  always @(posedge clk) begin
    tick_note_t note;
    result_t predicted, want;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        note = tick_notes.pop_front();
        predicted = dim_tick(item);
        pending_frames.push_back(note.fixed ? note.want : predicted);
      end
      if (result_valid && !result_stall) begin
        results_checked++;
        if (result.send_frame === 1'b1) frames_sent++;
        if (pending_frames.size() == 0) begin
          $error("result transfer with no tick pending");
          errors++;
        end else begin
          want = pending_frames.pop_front();
          check_field("send_frame", want.send_frame, result.send_frame);
          check_field("frame_ch1", want.frame_ch1, result.frame_ch1);
          check_field("frame_ch2", want.frame_ch2, result.frame_ch2);
          check_field("level_ch1", want.level_ch1, result.level_ch1);
          check_field("level_ch2", want.level_ch2, result.level_ch2);
        end
      end
    end
  end

  // result side back-pressure, changing its density after each window of random length
  int stall_window = 0;
  int stall_pct = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_window = $urandom_range(50, 400);
      end
      stall_window--;
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // tick sender: bursts of back-to-back transfers with idle gaps between
  task automatic send_tick(input item_t t, input bit fixed, input result_t want);
    tick_note_t note;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    note.fixed = fixed;
    note.want = want;
    tick_notes.push_back(note);
    item <= t;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    ticks_sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    while (results_checked < ticks_sent) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_readback(input logic [1:0] idx, input logic [31:0] want);
    paddr <= {idx, 2'b00};
    pwrite <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write every register; the first settings hit the extremes
  task automatic apply_settings(input int ph);
    logic par;
    logic [7:0] stp, mn;
    logic [1:0] ext;
    case (ph)
      0: begin par = 1'b0; stp = 8'd1;   mn = 8'd144; ext = 2'd0; end
      1: begin par = 1'b1; stp = 8'd3;   mn = 8'd0;   ext = 2'd1; end
      2: begin par = 1'b0; stp = 8'd255; mn = 8'd254; ext = 2'd2; end
      3: begin par = 1'b1; stp = 8'd0;   mn = 8'd255; ext = 2'd3; end
      4: begin par = 1'b0; stp = 8'd255; mn = 8'd255; ext = 2'd0; end
      5: begin par = 1'b0; stp = 8'd2;   mn = 8'd100; ext = 2'd3; end
      default: begin
        par = $urandom_range(0, 1);
        stp = $urandom_range(0, 10);
        mn = $urandom_range(0, 255);
        ext = $urandom_range(0, 3);
      end
    endcase
    reg_write(REG_PARALLEL, {31'd0, par});
    reg_write(REG_STEPS, {24'd0, stp});
    reg_write(REG_MIN_LEVEL, {24'd0, mn});
    reg_write(REG_EXT_MODE, {30'd0, ext});
    cfg_parallel = par;
    cfg_steps = stp;
    cfg_min = mn;
    cfg_ext = ext;
    reg_readback(REG_PARALLEL, {31'd0, par});
    reg_readback(REG_STEPS, {24'd0, stp});
    reg_readback(REG_MIN_LEVEL, {24'd0, mn});
    reg_readback(REG_EXT_MODE, {30'd0, ext});
    settings_used++;
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd254;
      2: return 8'd255;
      3: return cfg_min;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // random ticks against a lamp scene that holds for a while so ramps settle
  // and the repeat timer runs out; now and then a tick of pure noise
  function automatic item_t random_tick();
    item_t t;
    if ($urandom_range(0, 7) == 0) begin
      t = item_t'({$urandom, $urandom});
      return t;
    end
    if ($urandom_range(0, 14) == 0) begin
      scene.ch1_lamp_on = ($urandom_range(0, 3) != 0);
      scene.ch2_lamp_on = ($urandom_range(0, 3) != 0);
      scene.ch1_status_on = ($urandom_range(0, 7) == 0) ? !scene.ch1_lamp_on
                                                        : scene.ch1_lamp_on;
      scene.ch2_status_on = ($urandom_range(0, 7) == 0) ? !scene.ch2_lamp_on
                                                        : scene.ch2_lamp_on;
      scene.ch1_target = pick_level();
      scene.ch2_target = pick_level();
      scene.ext_level_ch1 = $urandom_range(0, 255);
      scene.ext_level_ch2 = $urandom_range(0, 255);
    end
    t = scene;
    t.operation = $urandom_range(0, 1) ? OP_OUTPUT : OP_RAMP;
    t.ch1_lux_hold = ($urandom_range(0, 4) == 0);
    t.ch1_force_load = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    t.ch2_force_load = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    return t;
  endfunction

  // directed ticks under the reset register values
  dir_row_t dir_rows [16] = '{
    // output tick right after reset: nothing changed, timer already at zero
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b1, '{1'b1, 8'd0, 8'd0, 8'd0, 8'd0}},
    // ramp up: jump to 144, then two single steps
    '{'{OP_RAMP, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b1, '{1'b0, 8'd0, 8'd0, 8'd146, 8'd146}},
    // lit output tick sends the new pair
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b1, '{1'b1, 8'd146, 8'd146, 8'd146, 8'd146}},
    // unchanged pair, no frame
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    // lux hold freezes channel 1, channel 2 ramps down past the floor to zero
    '{'{OP_RAMP, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    // channel 2 jumps to the floor, steps below it toward a zero target, then jumps back
    '{'{OP_RAMP, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    // force counters clear the last sent pair; lit zero level becomes 1
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd1},
      1'b0, '0},
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    '{'{OP_RAMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0},
      1'b0, '0},
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0},
      1'b0, '0},
    // every field but the operation at its top value
    '{'{OP_RAMP, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255}, 1'b0, '0},
    '{'{OP_OUTPUT, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255}, 1'b0, '0},
    '{'{OP_RAMP, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
      1'b0, '0},
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h55, 8'haa, 8'h55, 8'haa, 8'haa, 8'h55},
      1'b0, '0},
    '{'{OP_OUTPUT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'haa, 8'h55, 8'haa, 8'h55, 8'd0, 8'd0},
      1'b0, '0}
  };

  // main sequence
  initial begin
    int ph, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_tick(dir_rows[k].tick, dir_rows[k].fixed, dir_rows[k].want);
    end
    item_valid <= 1'b0;
    burst_left = 0;
    wait_drained();

    for (ph = 0; ph < NUM_SETTINGS; ph++) begin
      apply_settings(ph);
      for (k = 0; k < TICKS_PER_SETTING; k++) begin
        send_tick(random_tick(), 1'b0, '0);
      end
      item_valid <= 1'b0;
      burst_left = 0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_frames.size() != 0) begin
      $error("%0d expected results never arrived", pending_frames.size());
      errors++;
    end
    $display("ran %0d ticks under %0d register settings plus reset values",
             ticks_sent, settings_used);
    $display("checked %0d results, %0d with a frame sent", results_checked, frames_sent);
    if (errors == 0) begin
      $display("dual_channel_dim_ramp_and_send verification clean");
    end else begin
      $display("dual_channel_dim_ramp_and_send verification failed");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #60_000_000;
    $display("dual_channel_dim_ramp_and_send verification failed");
    $finish;
  end

endmodule

[dual_channel_dim_ramp_and_send.f]
hdl/dcdr_pkg.sv
hdl/dcdr_ramp_step.sv
hdl/dual_channel_dim_ramp_and_send.sv
bench/tb_top.sv
